/* sv/psm_pkg.sv */
// Shared types and constants for the permutation segment mutation block.
// Holds field widths, command codes and the controller/datapath interface structs.
`default_nettype none

package psm_pkg;

    localparam int MAX_CITIES = 256;
    localparam int CMD_W      = 3;
    localparam int POS_W      = 8;
    localparam int CITY_W     = 8;
    localparam int LEN_W      = 9;
    localparam logic [LEN_W-1:0] LEN_RESET = 9'd256;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE  = 3'd0,
        CMD_READ   = 3'd1,
        CMD_MOVE   = 3'd2,
        CMD_SWAP   = 3'd3,
        CMD_INVERT = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        RS_A,
        RS_B,
        RS_LO,
        RS_HI,
        RS_Q,
        RS_INC_LO,
        RS_DEC_HI,
        RS_DEC_Q
    } t_rsel;

    typedef enum logic [1:0] {
        WA_A,
        WA_P,
        WA_LO,
        WA_HI
    } t_wasel;

    typedef enum logic [1:0] {
        WD_CITY,
        WD_RD,
        WD_TMP
    } t_wdsel;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_READ,
        RES_MOD,
        RES_ERR
    } t_res;

    typedef struct packed {
        logic   load;
        t_rsel  rd_sel;
        logic   we;
        t_wasel wa_sel;
        t_wdsel wd_sel;
        logic   tmp_ld;
        logic   inv_init;
        logic   swap_init;
        logic   inv_step;
        logic   move_init;
        logic   move_step;
        logic   fin;
        t_res   res;
    } t_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             err_rw;
        logic             err_mut;
        logic             b_eq_a;
        logic             q_eq_a;
        logic             cnt_zero;
        logic             cnt_one;
    } t_sts;

endpackage

`default_nettype wire

/* sv/permutation_segment_mutation.sv */
// Move and invert run longer as dist and pairs grow; a position error or unknown cmd
// finishes without writing the tour memory. dist = circular distance pos_a to pos_b,
// pairs = (dist+1)/2.
// The next transaction is accepted in the cycle its predecessor's result shows; one
// transaction at a time. Each step is bound by the tour memory (one read, one write per cycle).
// Synchronous active-low reset clears the controller, result strobe and sets tour_length 256;
// tour memory contents are not reset. Results cannot be stalled.
`default_nettype none

module permutation_segment_mutation #(
    parameter int MAX_CITIES = psm_pkg::MAX_CITIES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [psm_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [psm_pkg::POS_W-1:0]   i_pos_a,
    input  wire logic [psm_pkg::POS_W-1:0]   i_pos_b,
    input  wire logic [psm_pkg::CITY_W-1:0]  i_city,
    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [psm_pkg::LEN_W-1:0]   i_cfg_tour_length,
    output logic                             o_valid,
    output logic [psm_pkg::CITY_W-1:0]       o_read_city,
    output logic                             o_modified,
    output logic                             o_error
);

    psm_pkg::t_ctl w_ctl;
    psm_pkg::t_sts w_sts;
    logic          w_cfg_we;

    assign o_cfg_ready = ~busy;
    assign w_cfg_we    = i_cfg_valid & o_cfg_ready;

    psm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .i_sts   (w_sts),
        .o_ctl   (w_ctl)
    );

    psm_dpath #(
        .MAX_CITIES (MAX_CITIES)
    ) u_dpath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_ctl             (w_ctl),
        .o_sts             (w_sts),
        .i_cmd             (i_cmd),
        .i_pos_a           (i_pos_a),
        .i_pos_b           (i_pos_b),
        .i_city            (i_city),
        .i_cfg_valid       (w_cfg_we),
        .i_cfg_tour_length (i_cfg_tour_length),
        .o_read_city       (o_read_city),
        .o_modified        (o_modified),
        .o_error           (o_error),
        .o_valid           (o_valid)
    );

endmodule

`default_nettype wire

/* sv/psm_dpath.sv */
// Datapath: tour memory, position pointers, length register and result registers.
// Driven by psm_ctrl through psm_pkg::t_ctl; reports through psm_pkg::t_sts.
`default_nettype none

module psm_dpath #(
    parameter int MAX_CITIES = psm_pkg::MAX_CITIES
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire psm_pkg::t_ctl               i_ctl,
    output psm_pkg::t_sts                    o_sts,
    input  wire logic [psm_pkg::CMD_W-1:0]   i_cmd,
    input  wire logic [psm_pkg::POS_W-1:0]   i_pos_a,
    input  wire logic [psm_pkg::POS_W-1:0]   i_pos_b,
    input  wire logic [psm_pkg::CITY_W-1:0]  i_city,
    input  wire logic                        i_cfg_valid,
    input  wire logic [psm_pkg::LEN_W-1:0]   i_cfg_tour_length,
    output logic [psm_pkg::CITY_W-1:0]       o_read_city,
    output logic                             o_modified,
    output logic                             o_error,
    output logic                             o_valid
);

    localparam int PW = $clog2(MAX_CITIES);
    localparam int NW = PW + 1;

    logic [psm_pkg::CITY_W-1:0] mem [MAX_CITIES];

    logic [psm_pkg::LEN_W-1:0]  r_len;
    logic [psm_pkg::CMD_W-1:0]  r_cmd;
    logic [psm_pkg::POS_W-1:0]  r_a;
    logic [psm_pkg::POS_W-1:0]  r_b;
    logic [psm_pkg::CITY_W-1:0] r_city;
    logic [psm_pkg::CITY_W-1:0] r_rd;
    logic [psm_pkg::CITY_W-1:0] r_tmp;
    logic [PW-1:0]              r_lo;
    logic [PW-1:0]              r_hi;
    logic [PW-1:0]              r_p;
    logic [PW-1:0]              r_q;
    logic [NW-1:0]              r_cnt;
    logic                       r_valid;
    logic [psm_pkg::CITY_W-1:0] r_out_city;
    logic                       r_out_mod;
    logic                       r_out_err;

    logic [NW-1:0]              w_n;
    logic [PW-1:0]              w_ia;
    logic [PW-1:0]              w_ib;
    logic                       w_err_a;
    logic                       w_err_b;
    logic [NW-1:0]              w_dist;
    logic [NW-1:0]              w_pairs;
    logic [PW-1:0]              w_ra;
    logic [PW-1:0]              w_wa;
    logic [psm_pkg::CITY_W-1:0] w_wd;

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] x, input logic [NW-1:0] n);
        logic [NW-1:0] s;
        s = {1'b0, x} + NW'(1);
        return (s == n) ? '0 : s[PW-1:0];
    endfunction

    function automatic logic [PW-1:0] f_dec(input logic [PW-1:0] x, input logic [NW-1:0] n);
        logic [NW-1:0] s;
        s = n - NW'(1);
        return (x == '0) ? s[PW-1:0] : x - PW'(1);
    endfunction

    always_comb begin
        if (32'(r_len) > MAX_CITIES) begin
            w_n = NW'(MAX_CITIES);
        end else begin
            w_n = NW'(r_len);
        end
    end

    assign w_ia    = PW'(r_a);
    assign w_ib    = PW'(r_b);
    assign w_err_a = 32'(r_a) >= 32'(w_n);
    assign w_err_b = 32'(r_b) >= 32'(w_n);

    always_comb begin
        if (w_ib >= w_ia) begin
            w_dist = NW'(w_ib) - NW'(w_ia);
        end else begin
            w_dist = NW'(w_ib) + w_n - NW'(w_ia);
        end
    end

    assign w_pairs = (w_dist + NW'(1)) >> 1;

    always_comb begin
        case (i_ctl.rd_sel)
            psm_pkg::RS_A:      w_ra = w_ia;
            psm_pkg::RS_B:      w_ra = w_ib;
            psm_pkg::RS_LO:     w_ra = r_lo;
            psm_pkg::RS_HI:     w_ra = r_hi;
            psm_pkg::RS_Q:      w_ra = r_q;
            psm_pkg::RS_INC_LO: w_ra = f_inc(r_lo, w_n);
            psm_pkg::RS_DEC_HI: w_ra = f_dec(r_hi, w_n);
            psm_pkg::RS_DEC_Q:  w_ra = f_dec(r_q, w_n);
            default:            w_ra = w_ia;
        endcase
    end

    always_comb begin
        case (i_ctl.wa_sel)
            psm_pkg::WA_A:  w_wa = w_ia;
            psm_pkg::WA_P:  w_wa = r_p;
            psm_pkg::WA_LO: w_wa = r_lo;
            psm_pkg::WA_HI: w_wa = r_hi;
            default:        w_wa = w_ia;
        endcase
    end

    always_comb begin
        case (i_ctl.wd_sel)
            psm_pkg::WD_CITY: w_wd = r_city;
            psm_pkg::WD_RD:   w_wd = r_rd;
            psm_pkg::WD_TMP:  w_wd = r_tmp;
            default:          w_wd = r_city;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            mem[w_wa] <= w_wd;
        end
        r_rd <= mem[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= psm_pkg::LEN_RESET;
        end else if (i_cfg_valid) begin
            r_len <= i_cfg_tour_length;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_cmd  <= i_cmd;
            r_a    <= i_pos_a;
            r_b    <= i_pos_b;
            r_city <= i_city;
        end
        if (i_ctl.tmp_ld) begin
            r_tmp <= r_rd;
        end
        if (i_ctl.inv_init) begin
            r_lo  <= w_ia;
            r_hi  <= w_ib;
            r_cnt <= w_pairs;
        end else if (i_ctl.swap_init) begin
            r_lo  <= w_ia;
            r_hi  <= w_ib;
            r_cnt <= NW'(1);
        end else if (i_ctl.inv_step) begin
            r_lo  <= f_inc(r_lo, w_n);
            r_hi  <= f_dec(r_hi, w_n);
            r_cnt <= r_cnt - NW'(1);
        end
        if (i_ctl.move_init) begin
            r_p <= w_ib;
            r_q <= f_dec(w_ib, w_n);
        end else if (i_ctl.move_step) begin
            r_p <= r_q;
            r_q <= f_dec(r_q, w_n);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fin) begin
            case (i_ctl.res)
                psm_pkg::RES_READ: begin
                    r_out_city <= r_rd;
                    r_out_mod  <= 1'b0;
                    r_out_err  <= 1'b0;
                end
                psm_pkg::RES_MOD: begin
                    r_out_city <= '0;
                    r_out_mod  <= 1'b1;
                    r_out_err  <= 1'b0;
                end
                psm_pkg::RES_ERR: begin
                    r_out_city <= '0;
                    r_out_mod  <= 1'b0;
                    r_out_err  <= 1'b1;
                end
                default: begin
                    r_out_city <= '0;
                    r_out_mod  <= 1'b0;
                    r_out_err  <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_ctl.fin;
        end
    end

    assign o_sts.cmd      = r_cmd;
    assign o_sts.err_rw   = w_err_a;
    assign o_sts.err_mut  = w_err_a | w_err_b;
    assign o_sts.b_eq_a   = (r_b == r_a);
    assign o_sts.q_eq_a   = (r_q == w_ia);
    assign o_sts.cnt_zero = (r_cnt == '0);
    assign o_sts.cnt_one  = (r_cnt == NW'(1));

    assign o_read_city = r_out_city;
    assign o_modified  = r_out_mod;
    assign o_error     = r_out_err;
    assign o_valid     = r_valid;

    a_mod_err_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_modified && o_error))
        else $error("modified and error both set");

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_error) |-> (o_read_city == '0))
        else $error("read data on error result");

    a_valid_after_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_ctl.fin))
        else $error("result strobe without finish");

endmodule

`default_nettype wire

/* sv/psm_ctrl.sv */
// Controller: sequences memory accesses for write, read, move, swap and invert.
// Uses psm_pkg command codes and control/status structs; drives psm_dpath.
`default_nettype none

module psm_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    output logic               o_busy,
    input  wire psm_pkg::t_sts i_sts,
    output psm_pkg::t_ctl      o_ctl
);

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b00_0000_0001,
        ST_CHK     = 10'b00_0000_0010,
        ST_RD_OUT  = 10'b00_0000_0100,
        ST_M_SEL   = 10'b00_0000_1000,
        ST_M_SHIFT = 10'b00_0001_0000,
        ST_M_PUT   = 10'b00_0010_0000,
        ST_I_RLO   = 10'b00_0100_0000,
        ST_I_RHI   = 10'b00_1000_0000,
        ST_I_WLO   = 10'b01_0000_0000,
        ST_I_WHI   = 10'b10_0000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_ctl   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    o_ctl.load = 1'b1;
                    n_state    = ST_CHK;
                end
            end
            ST_CHK: begin
                case (i_sts.cmd)
                    psm_pkg::CMD_WRITE: begin
                        o_ctl.fin = 1'b1;
                        n_state   = ST_IDLE;
                        if (i_sts.err_rw) begin
                            o_ctl.res = psm_pkg::RES_ERR;
                        end else begin
                            o_ctl.we     = 1'b1;
                            o_ctl.wa_sel = psm_pkg::WA_A;
                            o_ctl.wd_sel = psm_pkg::WD_CITY;
                            o_ctl.res    = psm_pkg::RES_NONE;
                        end
                    end
                    psm_pkg::CMD_READ: begin
                        if (i_sts.err_rw) begin
                            o_ctl.fin = 1'b1;
                            o_ctl.res = psm_pkg::RES_ERR;
                            n_state   = ST_IDLE;
                        end else begin
                            o_ctl.rd_sel = psm_pkg::RS_A;
                            n_state      = ST_RD_OUT;
                        end
                    end
                    psm_pkg::CMD_MOVE: begin
                        if (i_sts.err_mut) begin
                            o_ctl.fin = 1'b1;
                            o_ctl.res = psm_pkg::RES_ERR;
                            n_state   = ST_IDLE;
                        end else begin
                            o_ctl.move_init = 1'b1;
                            o_ctl.rd_sel    = psm_pkg::RS_B;
                            n_state         = ST_M_SEL;
                        end
                    end
                    psm_pkg::CMD_SWAP, psm_pkg::CMD_INVERT: begin
                        if (i_sts.err_mut) begin
                            o_ctl.fin = 1'b1;
                            o_ctl.res = psm_pkg::RES_ERR;
                            n_state   = ST_IDLE;
                        end else begin
                            if (i_sts.cmd == psm_pkg::CMD_SWAP) begin
                                o_ctl.swap_init = 1'b1;
                            end else begin
                                o_ctl.inv_init = 1'b1;
                            end
                            n_state = ST_I_RLO;
                        end
                    end
                    default: begin
                        o_ctl.fin = 1'b1;
                        o_ctl.res = psm_pkg::RES_NONE;
                        n_state   = ST_IDLE;
                    end
                endcase
            end
            ST_RD_OUT: begin
                o_ctl.fin = 1'b1;
                o_ctl.res = psm_pkg::RES_READ;
                n_state   = ST_IDLE;
            end
            ST_M_SEL: begin
                o_ctl.tmp_ld = 1'b1;
                if (i_sts.b_eq_a) begin
                    n_state = ST_M_PUT;
                end else begin
                    o_ctl.rd_sel = psm_pkg::RS_Q;
                    n_state      = ST_M_SHIFT;
                end
            end
            ST_M_SHIFT: begin
                o_ctl.we        = 1'b1;
                o_ctl.wa_sel    = psm_pkg::WA_P;
                o_ctl.wd_sel    = psm_pkg::WD_RD;
                o_ctl.rd_sel    = psm_pkg::RS_DEC_Q;
                o_ctl.move_step = 1'b1;
                if (i_sts.q_eq_a) begin
                    n_state = ST_M_PUT;
                end
            end
            ST_M_PUT: begin
                o_ctl.we     = 1'b1;
                o_ctl.wa_sel = psm_pkg::WA_A;
                o_ctl.wd_sel = psm_pkg::WD_TMP;
                o_ctl.fin    = 1'b1;
                o_ctl.res    = psm_pkg::RES_MOD;
                n_state      = ST_IDLE;
            end
            ST_I_RLO: begin
                if (i_sts.cnt_zero) begin
                    o_ctl.fin = 1'b1;
                    o_ctl.res = psm_pkg::RES_MOD;
                    n_state   = ST_IDLE;
                end else begin
                    o_ctl.rd_sel = psm_pkg::RS_LO;
                    n_state      = ST_I_RHI;
                end
            end
            ST_I_RHI: begin
                o_ctl.rd_sel = psm_pkg::RS_HI;
                o_ctl.tmp_ld = 1'b1;
                n_state      = ST_I_WLO;
            end
            ST_I_WLO: begin
                o_ctl.we     = 1'b1;
                o_ctl.wa_sel = psm_pkg::WA_LO;
                o_ctl.wd_sel = psm_pkg::WD_RD;
                o_ctl.rd_sel = psm_pkg::RS_INC_LO;
                n_state      = ST_I_WHI;
            end
            ST_I_WHI: begin
                o_ctl.we       = 1'b1;
                o_ctl.wa_sel   = psm_pkg::WA_HI;
                o_ctl.wd_sel   = psm_pkg::WD_TMP;
                o_ctl.rd_sel   = psm_pkg::RS_DEC_HI;
                o_ctl.tmp_ld   = 1'b1;
                o_ctl.inv_step = 1'b1;
                if (i_sts.cnt_one) begin
                    o_ctl.fin = 1'b1;
                    o_ctl.res = psm_pkg::RES_MOD;
                    n_state   = ST_IDLE;
                end else begin
                    n_state = ST_I_WLO;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != ST_IDLE);

    a_start_takes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == ST_CHK))
        else $error("accepted transaction not decoded");

    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.fin |=> !o_busy)
        else $error("busy after finish");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.we |-> o_busy)
        else $error("memory write while idle");

endmodule

`default_nettype wire

/* bench/permutation_segment_mutation_tb.sv */
// Self-checking bench for permutation_segment_mutation: a directed table, then random phases
// over several tour lengths, every result checked against the in-bench tour predictor or a typed row's result.
// Depends on psm_pkg and the permutation_segment_mutation RTL.

module permutation_segment_mutation_tb;

    localparam logic [psm_pkg::CMD_W-1:0] CMD_RSVD_5 = 3'd5;
    localparam logic [psm_pkg::CMD_W-1:0] CMD_RSVD_7 = 3'd7;
    localparam int IDLE_PCT     = 14;
    localparam int PHASE_ITEMS  = 90;
    localparam int STEADY_PHASE = 3;
    localparam int NUM_PHASES   = 12;

    typedef struct {
        logic [psm_pkg::CITY_W-1:0] read_city;
        logic                       modified;
        logic                       error;
    } t_tour_result;

    typedef struct {
        bit                         set_len;
        logic [psm_pkg::LEN_W-1:0]  len;
        logic [psm_pkg::CMD_W-1:0]  cmd;
        logic [psm_pkg::POS_W-1:0]  pos_a;
        logic [psm_pkg::POS_W-1:0]  pos_b;
        logic [psm_pkg::CITY_W-1:0] city;
        bit                         typed;
        t_tour_result               res;
    } t_dir_row;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         start;
    logic                         busy;
    logic [psm_pkg::CMD_W-1:0]    i_cmd;
    logic [psm_pkg::POS_W-1:0]    i_pos_a;
    logic [psm_pkg::POS_W-1:0]    i_pos_b;
    logic [psm_pkg::CITY_W-1:0]   i_city;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [psm_pkg::LEN_W-1:0]    i_cfg_tour_length;
    logic                         o_valid;
    logic [psm_pkg::CITY_W-1:0]   o_read_city;
    logic                         o_modified;
    logic                         o_error;

    logic [psm_pkg::CITY_W-1:0]   tour_copy [psm_pkg::MAX_CITIES];
    logic [psm_pkg::LEN_W-1:0]    tour_len_copy;
    t_tour_result                 awaited_results [$];
    t_dir_row                     dir_rows [$];
    logic [psm_pkg::LEN_W-1:0]    phase_lengths [NUM_PHASES];
    int                           mismatch_count;
    int                           idle_pct;

    permutation_segment_mutation dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_cmd             (i_cmd),
        .i_pos_a           (i_pos_a),
        .i_pos_b           (i_pos_b),
        .i_city            (i_city),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_tour_length (i_cfg_tour_length),
        .o_valid           (o_valid),
        .o_read_city       (o_read_city),
        .o_modified        (o_modified),
        .o_error           (o_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic int eff_tour_len();
        return (tour_len_copy > psm_pkg::MAX_CITIES) ? psm_pkg::MAX_CITIES
                                                     : int'(tour_len_copy);
    endfunction

    // Tour predictor: one command against the bench's own copy of the store.
    task automatic apply_tour_cmd(input logic [psm_pkg::CMD_W-1:0] c,
                                  input logic [psm_pkg::POS_W-1:0] a,
                                  input logic [psm_pkg::POS_W-1:0] b,
                                  input logic [psm_pkg::CITY_W-1:0] city,
                                  output t_tour_result res);
        int n;
        int span;
        int lo;
        int hi;
        logic [psm_pkg::CITY_W-1:0] held;
        n = eff_tour_len();
        res = '{8'd0, 1'b0, 1'b0};
        if (c == psm_pkg::CMD_WRITE || c == psm_pkg::CMD_READ) begin
            if (a >= n) begin
                res.error = 1'b1;
            end else if (c == psm_pkg::CMD_WRITE) begin
                tour_copy[a] = city;
            end else begin
                res.read_city = tour_copy[a];
            end
        end else if (c == psm_pkg::CMD_MOVE || c == psm_pkg::CMD_SWAP ||
                     c == psm_pkg::CMD_INVERT) begin
            if (a >= n || b >= n) begin
                res.error = 1'b1;
            end else begin
                res.modified = 1'b1;
                span = (int'(b) + n - int'(a)) % n;
                if (c == psm_pkg::CMD_MOVE) begin
                    held = tour_copy[b];
                    for (int k = span; k > 0; k--)
                        tour_copy[(a + k) % n] = tour_copy[(a + k - 1) % n];
                    tour_copy[a] = held;
                end else if (c == psm_pkg::CMD_SWAP) begin
                    held = tour_copy[a];
                    tour_copy[a] = tour_copy[b];
                    tour_copy[b] = held;
                end else begin
                    for (int k = 0; k < (span + 1) / 2; k++) begin
                        lo = (a + k) % n;
                        hi = (a + span - k) % n;
                        held = tour_copy[lo];
                        tour_copy[lo] = tour_copy[hi];
                        tour_copy[hi] = held;
                    end
                end
            end
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $time);
        mismatch_count++;
    endtask

    // Hold off until every result is back, then write the length register.
    task automatic set_tour_length(input logic [psm_pkg::LEN_W-1:0] v);
        start <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_tour_length <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        tour_len_copy = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic issue_item(input logic [psm_pkg::CMD_W-1:0] c,
                              input logic [psm_pkg::POS_W-1:0] a,
                              input logic [psm_pkg::POS_W-1:0] b,
                              input logic [psm_pkg::CITY_W-1:0] city,
                              input bit typed, input t_tour_result typed_res);
        t_tour_result res;
        if ($urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        end
        start   <= 1'b1;
        i_cmd   <= c;
        i_pos_a <= a;
        i_pos_b <= b;
        i_city  <= city;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        apply_tour_cmd(c, a, b, city, res);
        awaited_results.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    function automatic t_dir_row cfg_row(input logic [psm_pkg::LEN_W-1:0] v);
        return '{1'b1, v, psm_pkg::CMD_WRITE, 8'd0, 8'd0, 8'd0, 1'b0, '{8'd0, 1'b0, 1'b0}};
    endfunction

    function automatic t_dir_row item_row(input logic [psm_pkg::CMD_W-1:0] c,
                                          input logic [psm_pkg::POS_W-1:0] a,
                                          input logic [psm_pkg::POS_W-1:0] b,
                                          input logic [psm_pkg::CITY_W-1:0] city);
        return '{1'b0, 9'd0, c, a, b, city, 1'b0, '{8'd0, 1'b0, 1'b0}};
    endfunction

    function automatic t_dir_row typed_row(input logic [psm_pkg::CMD_W-1:0] c,
                                           input logic [psm_pkg::POS_W-1:0] a,
                                           input logic [psm_pkg::POS_W-1:0] b,
                                           input logic [psm_pkg::CITY_W-1:0] city,
                                           input logic [psm_pkg::CITY_W-1:0] rd,
                                           input logic md, input logic er);
        return '{1'b0, 9'd0, c, a, b, city, 1'b1, '{rd, md, er}};
    endfunction

    always @(posedge i_clk) begin
        t_tour_result want;
        if (i_rst_n && o_valid) begin
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing pending", o_read_city, 0);
            end else begin
                want = awaited_results.pop_front();
                if (o_read_city !== want.read_city)
                    report_mismatch("read_city", o_read_city, want.read_city);
                if (o_modified !== want.modified)
                    report_mismatch("modified", o_modified, want.modified);
                if (o_error !== want.error)
                    report_mismatch("error", o_error, want.error);
            end
        end
    end

    initial begin
        int n;
        int pick;
        int j;
        logic [psm_pkg::CMD_W-1:0]  c;
        logic [psm_pkg::POS_W-1:0]  a;
        logic [psm_pkg::POS_W-1:0]  b;
        logic [psm_pkg::CITY_W-1:0] city;
        logic [psm_pkg::CITY_W-1:0] held;
        logic [psm_pkg::CITY_W-1:0] deck [psm_pkg::MAX_CITIES];
        t_tour_result               none_res;

        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_cmd             = psm_pkg::CMD_WRITE;
        i_pos_a           = '0;
        i_pos_b           = '0;
        i_city            = '0;
        i_cfg_valid       = 1'b0;
        i_cfg_tour_length = '0;
        mismatch_count    = 0;
        idle_pct          = IDLE_PCT;
        none_res          = '{8'd0, 1'b0, 1'b0};
        tour_len_copy     = psm_pkg::LEN_RESET;
        for (int i = 0; i < psm_pkg::MAX_CITIES; i++) tour_copy[i] = '0;
        phase_lengths = '{9'd256, 9'd2, 9'd37, 9'd256, 9'd511, 9'd3,
                          9'd128, 9'd257, 9'd1, 9'd200, 9'd0, 9'd256};

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Mutations stay on written positions until the full load below.
        dir_rows.push_back(cfg_row(9'd4));
        dir_rows.push_back(typed_row(psm_pkg::CMD_WRITE, 8'd0, 8'd0, 8'hFF, 8'd0, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_WRITE, 8'd1, 8'hFF, 8'h00, 8'd0, 1'b0, 1'b0));
        dir_rows.push_back(item_row(psm_pkg::CMD_WRITE, 8'd2, 8'd0, 8'h5A));
        dir_rows.push_back(item_row(psm_pkg::CMD_WRITE, 8'd3, 8'd0, 8'hA5));
        dir_rows.push_back(typed_row(psm_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 8'hFF, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_READ, 8'd3, 8'd0, 8'd0, 8'hA5, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_WRITE, 8'd4, 8'd0, 8'h77, 8'd0, 1'b0, 1'b1));
        dir_rows.push_back(typed_row(psm_pkg::CMD_READ, 8'hFF, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
        dir_rows.push_back(item_row(psm_pkg::CMD_MOVE, 8'd3, 8'd1, 8'd0));
        dir_rows.push_back(item_row(psm_pkg::CMD_SWAP, 8'd0, 8'd3, 8'd0));
        dir_rows.push_back(item_row(psm_pkg::CMD_INVERT, 8'd2, 8'd1, 8'd0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_INVERT, 8'd1, 8'd1, 8'd0, 8'd0, 1'b1, 1'b0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_MOVE, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_MOVE, 8'd0, 8'd4, 8'd0, 8'd0, 1'b0, 1'b1));
        dir_rows.push_back(typed_row(psm_pkg::CMD_SWAP, 8'hFF, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
        dir_rows.push_back(typed_row(CMD_RSVD_5, 8'd1, 8'd2, 8'h11, 8'd0, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(CMD_RSVD_7, 8'hFF, 8'hFF, 8'hFF, 8'd0, 1'b0, 1'b0));
        dir_rows.push_back(item_row(psm_pkg::CMD_READ, 8'd1, 8'd0, 8'd0));
        dir_rows.push_back(item_row(psm_pkg::CMD_READ, 8'd2, 8'd0, 8'd0));
        dir_rows.push_back(cfg_row(9'd1));
        dir_rows.push_back(item_row(psm_pkg::CMD_READ, 8'd0, 8'd0, 8'd0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_READ, 8'd1, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
        dir_rows.push_back(typed_row(psm_pkg::CMD_SWAP, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, 1'b0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_MOVE, 8'd0, 8'd1, 8'd0, 8'd0, 1'b0, 1'b1));
        dir_rows.push_back(cfg_row(9'd0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_READ, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1));
        dir_rows.push_back(typed_row(psm_pkg::CMD_WRITE, 8'd0, 8'd0, 8'h99, 8'd0, 1'b0, 1'b1));
        dir_rows.push_back(cfg_row(9'd511));
        dir_rows.push_back(typed_row(psm_pkg::CMD_WRITE, 8'hFF, 8'd0, 8'h3C, 8'd0, 1'b0, 1'b0));
        dir_rows.push_back(typed_row(psm_pkg::CMD_READ, 8'hFF, 8'd0, 8'd0, 8'h3C, 1'b0, 1'b0));

        foreach (dir_rows[i]) begin
            if (dir_rows[i].set_len) begin
                set_tour_length(dir_rows[i].len);
            end else begin
                issue_item(dir_rows[i].cmd, dir_rows[i].pos_a, dir_rows[i].pos_b,
                           dir_rows[i].city, dir_rows[i].typed, dir_rows[i].res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_tour_length(phase_lengths[p]);
            n = eff_tour_len();
            idle_pct = (p == STEADY_PHASE) ? 0 : IDLE_PCT;
            if (p == 0) begin
                // Load a shuffled permutation into every position.
                for (int i = 0; i < psm_pkg::MAX_CITIES; i++)
                    deck[i] = psm_pkg::CITY_W'(i);
                for (int i = psm_pkg::MAX_CITIES - 1; i > 0; i--) begin
                    j = $urandom_range(0, i);
                    held = deck[i];
                    deck[i] = deck[j];
                    deck[j] = held;
                end
                for (int i = 0; i < psm_pkg::MAX_CITIES; i++)
                    issue_item(psm_pkg::CMD_WRITE, psm_pkg::POS_W'(i),
                               psm_pkg::POS_W'($urandom_range(0, 255)), deck[i],
                               1'b0, none_res);
            end
            for (int i = 0; i < PHASE_ITEMS; i++) begin
                pick = $urandom_range(0, 99);
                if (pick < 5)       c = psm_pkg::CMD_W'($urandom_range(CMD_RSVD_5, CMD_RSVD_7));
                else if (pick < 20) c = psm_pkg::CMD_WRITE;
                else if (pick < 45) c = psm_pkg::CMD_READ;
                else if (pick < 63) c = psm_pkg::CMD_MOVE;
                else if (pick < 81) c = psm_pkg::CMD_SWAP;
                else                c = psm_pkg::CMD_INVERT;
                if (n == 0 || $urandom_range(0, 99) < 8)
                    a = psm_pkg::POS_W'($urandom_range(0, 255));
                else
                    a = psm_pkg::POS_W'($urandom_range(0, n - 1));
                if (n == 0 || $urandom_range(0, 99) < 8)
                    b = psm_pkg::POS_W'($urandom_range(0, 255));
                else
                    b = psm_pkg::POS_W'($urandom_range(0, n - 1));
                if ($urandom_range(0, 99) < 5) b = a;
                city = psm_pkg::CITY_W'($urandom_range(0, 255));
                issue_item(c, a, b, city, 1'b0, none_res);
            end
        end

        start <= 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
